FILE: hdl/rog_pkg.sv
// Package for the render overload governor: widths, limits and codes.
`default_nettype none
package rog_pkg;

  // Shared multiplier operand and product widths
  localparam int unsigned MulAW = 24;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Window qualification and overload limits
  localparam logic [15:0] FpsFloorQ4    = 16'd384;
  localparam logic [15:0] MinSamples    = 16'd10;
  localparam logic [5:0]  HeadroomMin   = 6'd10;
  localparam logic [5:0]  HeadroomMax   = 6'd40;
  localparam logic [6:0]  PercentFull   = 7'd100;
  localparam logic [17:0] BudgetScale   = 18'd160000;
  localparam logic [17:0] FrameRatioScl = 18'd1600;
  localparam logic [23:0] AvLimitUs     = 24'd50000;
  localparam logic [23:0] P95NonFinite  = 24'hFFFFFF;
  localparam logic [23:0] AvCodeMin     = 24'h800000;
  localparam logic [23:0] AvCodeMax     = 24'h7FFFFF;

  // Register reset values
  localparam logic [3:0] FallbackRst  = 4'd2;
  localparam logic [5:0] HeadroomRst  = 6'd20;
  localparam logic [3:0] ReqOvlRst    = 4'd3;
  localparam logic [7:0] InitWarmRst  = 8'd3;
  localparam logic [7:0] PostWarmRst  = 8'd3;

  // Register indexes
  localparam logic [2:0] RegFallback = 3'd0;
  localparam logic [2:0] RegHeadroom = 3'd1;
  localparam logic [2:0] RegReqOvl   = 3'd2;
  localparam logic [2:0] RegInitWarm = 3'd3;
  localparam logic [2:0] RegPostWarm = 3'd4;

  // Action codes
  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActDown    = 2'd1;
  localparam logic [1:0] ActDisable = 2'd2;

endpackage
`default_nettype wire

FILE: hdl/rog_mul.sv
// Shared multiplier with a registered product.
`default_nettype none
module rog_mul import rog_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [MulAW-1:0] a_i,
  input  wire logic [MulBW-1:0] b_i,
  output logic      [MulPW-1:0] p_o
);

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: hdl/render_overload_governor.sv
// Render overload governor: top level with sequencer, state and output register.
// Four sequencer steps run from request acceptance to result valid, sharing one
//   24x18 multiplier: threshold, p95, frames, decide.
// Requests are taken only in idle; the multiplier is reused three times per
//   window, and a held result stalls only the final step.
// Reset (async, active low): registers take their reset values and the
//   governor state is loaded from them; the result register is emptied.
`default_nettype none
module render_overload_governor import rog_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // playing[0] buffering[1] paused[2] render_samples[18:3] fps_q4[34:19]
  // render_p95_us[58:35] av_sync_us[82:59] dropped_frames[98:83]
  // mistimed_frames[114:99] delayed_frames[130:115], zero pad [135:131]
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[1:0] overloaded[2] fallbacks_left[6:3], zero pad [7]
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [7:0]   cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StThr  = 3'd1;
  localparam logic [2:0] StP95  = 3'd2;
  localparam logic [2:0] StFrm  = 3'd3;
  localparam logic [2:0] StDec  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration
  logic [3:0] fallback_cnt_q;
  logic [5:0] headroom_q;
  logic [3:0] req_ovl_q;
  logic [7:0] init_warm_q;
  logic [7:0] post_warm_q;

  // governor state
  logic [7:0] warm_q, warm_d;
  logic [3:0] run_q, run_d;
  logic [3:0] fb_q, fb_d;
  logic       last_q, last_d;

  // captured window
  logic        playing_q, buffering_q, paused_q;
  logic [15:0] samples_q, fps_q;
  logic [23:0] p95_q, av_q;
  logic [17:0] frames_q;

  logic [23:0] thr_q;
  logic        ovl_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  logic        out_valid_q;
  logic [1:0]  out_act_q;
  logic        out_ovl_q;
  logic [3:0]  out_fb_q;

  logic        in_acc, out_free, dec_go, win_valid, win_ovl, frm_ovl;
  logic [15:0] f_eff;
  logic [23:0] av_mag;
  logic [3:0]  run_inc;
  logic [1:0]  act_d;
  logic [5:0]  hr_clamp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign dec_go   = (state_q == StDec) && out_free;
  assign s_axis_tready = (state_q == StIdle);

  assign f_eff  = (fps_q < FpsFloorQ4) ? FpsFloorQ4 : fps_q;
  assign av_mag = av_q[23] ? (24'd0 - av_q) : av_q;

  always_comb begin
    case (state_q)
      StThr: begin
        mul_a = MulAW'(PercentFull - {1'b0, headroom_q});
        mul_b = BudgetScale;
      end
      StP95: begin
        mul_a = p95_q;
        mul_b = MulBW'(f_eff);
      end
      // operands held while the decision waits, so the frames product stays put
      StFrm, StDec: begin
        mul_a = MulAW'(frames_q);
        mul_b = FrameRatioScl;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rog_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    case (state_q)
      StIdle:  state_d = in_acc ? StThr : StIdle;
      StThr:   state_d = StP95;
      StP95:   state_d = StFrm;
      StFrm:   state_d = StDec;
      StDec:   state_d = out_free ? StIdle : StDec;
      default: state_d = StIdle;
    endcase
  end

  // frame-count test; product of the frames step is available in StDec
  assign frm_ovl = mul_p > MulPW'(f_eff);
  assign win_ovl = ovl_q || frm_ovl || (p95_q == P95NonFinite) ||
                   (av_q == AvCodeMin) || (av_q == AvCodeMax) ||
                   (av_mag > AvLimitUs);
  assign win_valid = playing_q && !buffering_q && !paused_q &&
                     (samples_q >= MinSamples) && (fps_q != 16'd0);
  assign run_inc = run_q + 4'd1;

  always_comb begin
    warm_d = warm_q;
    run_d  = run_q;
    fb_d   = fb_q;
    last_d = last_q;
    act_d  = ActNone;
    if (!win_valid) begin
      run_d  = '0;
      last_d = 1'b0;
    end else if (warm_q != 8'd0) begin
      warm_d = warm_q - 8'd1;
      run_d  = '0;
      last_d = 1'b0;
    end else begin
      last_d = win_ovl;
      if (!win_ovl) begin
        run_d = '0;
      end else if (run_inc >= req_ovl_q) begin
        run_d  = '0;
        warm_d = post_warm_q;
        if (fb_q != 4'd0) begin
          fb_d  = fb_q - 4'd1;
          act_d = ActDown;
        end else begin
          act_d = ActDisable;
        end
      end else begin
        run_d = run_inc;
      end
    end
  end

  always_comb begin
    if (cfg_data_i[5:0] < HeadroomMin) begin
      hr_clamp = HeadroomMin;
    end else if (cfg_data_i[5:0] > HeadroomMax) begin
      hr_clamp = HeadroomMax;
    end else begin
      hr_clamp = cfg_data_i[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      fallback_cnt_q <= FallbackRst;
      headroom_q     <= HeadroomRst;
      req_ovl_q      <= ReqOvlRst;
      init_warm_q    <= InitWarmRst;
      post_warm_q    <= PostWarmRst;
      warm_q         <= InitWarmRst;
      run_q          <= '0;
      fb_q           <= FallbackRst;
      last_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (dec_go) begin
        warm_q      <= warm_d;
        run_q       <= run_d;
        fb_q        <= fb_d;
        last_q      <= last_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // user must write in idle, not enforced; any valid index reloads the state
      if (cfg_we_i && (cfg_idx_i <= RegPostWarm) && !dec_go) begin
        run_q  <= '0;
        last_q <= 1'b0;
        warm_q <= (cfg_idx_i == RegInitWarm) ? cfg_data_i : init_warm_q;
        fb_q   <= (cfg_idx_i == RegFallback) ? cfg_data_i[3:0] : fallback_cnt_q;
        case (cfg_idx_i)
          RegFallback: fallback_cnt_q <= cfg_data_i[3:0];
          RegHeadroom: headroom_q     <= hr_clamp;
          RegReqOvl:   req_ovl_q      <= cfg_data_i[3:0];
          RegInitWarm: init_warm_q    <= cfg_data_i;
          RegPostWarm: post_warm_q    <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      playing_q   <= s_axis_tdata[0];
      buffering_q <= s_axis_tdata[1];
      paused_q    <= s_axis_tdata[2];
      samples_q   <= s_axis_tdata[18:3];
      fps_q       <= s_axis_tdata[34:19];
      p95_q       <= s_axis_tdata[58:35];
      av_q        <= s_axis_tdata[82:59];
      frames_q    <= 18'(s_axis_tdata[98:83]) + 18'(s_axis_tdata[114:99]) +
                     18'(s_axis_tdata[130:115]);
    end
    if (state_q == StP95) begin
      thr_q <= mul_p[23:0];
    end
    if (state_q == StFrm) begin
      ovl_q <= mul_p > MulPW'(thr_q);
    end
    if (dec_go) begin
      out_act_q <= act_d;
      out_ovl_q <= last_d;
      out_fb_q  <= fb_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_fb_q, out_ovl_q, out_act_q};

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StThr))
    else $error("accepted request did not start the sequencer");

  a_dec_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_go |=> out_valid_q)
    else $error("decision step did not load a result");

  a_disable_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q == ActDisable) |-> (out_fb_q == 4'd0))
    else $error("disable issued with fallbacks left");

  a_act_overload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_act_q != ActNone) |-> out_ovl_q)
    else $error("action on a window not judged overloaded");

  a_headroom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StThr) |-> (headroom_q >= HeadroomMin && headroom_q <= HeadroomMax))
    else $error("headroom outside clamp range");

endmodule
`default_nettype wire
